// ----- rtl/jsv_pkg.sv -----
// Shared types, constants and character-class helpers for the JSON syntax validator.
package jsv_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DEPTH_W     = 6;
	localparam int CFG_AW      = 3;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST = DEPTH_W'(32);

	localparam logic REG_MAX_DEPTH = 1'b0;

	typedef enum logic [1:0] {
		ST_PENDING = 2'd0,
		ST_ACCEPT  = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		M_VALUE     = 5'd0,
		M_ARR_FIRST = 5'd1,
		M_OBJ_FIRST = 5'd2,
		M_KEY       = 5'd3,
		M_COLON     = 5'd4,
		M_AFTER     = 5'd5,
		M_VSTR      = 5'd6,
		M_VESC      = 5'd7,
		M_VHEX      = 5'd8,
		M_KSTR      = 5'd9,
		M_KESC      = 5'd10,
		M_KHEX      = 5'd11,
		M_LIT       = 5'd12,
		M_NMINUS    = 5'd13,
		M_NZERO     = 5'd14,
		M_NINT      = 5'd15,
		M_NDOT      = 5'd16,
		M_NFRAC     = 5'd17,
		M_NE        = 5'd18,
		M_NESIGN    = 5'd19,
		M_NEXP      = 5'd20
	} mode_t;

	typedef enum logic [1:0] {
		LIT_TRUE  = 2'd0,
		LIT_FALSE = 2'd1,
		LIT_NULL  = 2'd2
	} lit_kind_t;

	typedef struct packed {
		status_t             status;
		logic [DEPTH_W-1:0]  level;
	} result_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
			((b >= 8'h41) && (b <= 8'h46));
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] kind);
		logic [2:0] n;
		n = 3'd4;
		if (kind == LIT_FALSE) n = 3'd5;
		return n;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (kind)
			LIT_TRUE: begin
				case (pos)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "u";
					3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				case (pos)
					3'd0: c = "f";
					3'd1: c = "a";
					3'd2: c = "l";
					3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			LIT_NULL: begin
				case (pos)
					3'd0: c = "n";
					3'd1: c = "u";
					3'd2: c = "l";
					3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/jsv_if.sv -----
// Valid/ready channel interfaces for document bytes and per-byte verdicts.
interface jsv_byte_if;
	import jsv_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface jsv_verdict_if;
	import jsv_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [DEPTH_W-1:0] nesting_level;

	modport source(output valid, output status, output nesting_level, input ready);
	modport sink(input valid, input status, input nesting_level, output ready);
endinterface

// ----- rtl/json_syntax_validator_top.sv -----
// JSON syntax validator: byte-wise parser FSM with a container stack held in a RAM.
//
//  channel   dir  handshake        payload
//  doc       in   valid/ready      data_byte[7:0], last_byte
//  verdict   out  valid/ready      status[1:0], nesting_level[5:0]
//  apb       cfg  psel/penable     paddr[2:0], pwdata/prdata[31:0]; max_depth at 0x0
//
// One byte per cycle while the result queue has room. Each byte is parsed in
// the cycle it is taken; the stack RAM read for the entry below the top is
// issued from the next depth and registered, so a pop finds its new top ready.
// A two-entry result queue keeps bytes flowing while the verdict side stalls;
// doc.ready drops only when both entries are full. arst_n clears the parser,
// the queue and max_depth (to 32); no RAM clearing pass is needed.
module json_syntax_validator_top import jsv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	jsv_byte_if.sink            doc,
	jsv_verdict_if.source       verdict,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// configuration
	logic [DEPTH_W-1:0] max_depth_q;
	logic [DEPTH_W-1:0] limit;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= MAX_DEPTH_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_DEPTH)) begin
			max_depth_q <= pwdata[DEPTH_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_DEPTH: prdata = {{(32-DEPTH_W){1'b0}}, max_depth_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign limit = (max_depth_q < DEPTH_W'(STACK_DEPTH)) ? max_depth_q : DEPTH_W'(STACK_DEPTH);

	// parser state
	mode_t              mode_q, mode_n;
	logic [DEPTH_W-1:0] depth_q, depth_n;
	logic [2:0]         lpos_q, lpos_n;
	logic [2:0]         hex_q, hex_n;
	logic [1:0]         lkind_q, lkind_n;
	logic               rej_q, rej_n;
	logic               top_q, top_n;

	// stack RAM: one bit per level, 1 object / 0 array
	logic               stack_mem [STACK_DEPTH];
	logic               below_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_wa;
	logic               mem_wd;
	logic [ADDR_W-1:0]  mem_ra;

	logic               acc;
	result_t            res;

	// result queue
	result_t            slot0_q, slot1_q;
	logic [1:0]         cnt_q;
	logic               pop;

	assign acc = doc.valid && doc.ready;
	assign doc.ready = (cnt_q != 2'd2);
	assign pop = (cnt_q != 2'd0) && verdict.ready;

	always_comb begin
		logic [7:0]         b;
		logic               ok;
		logic               sv;
		logic               av;
		logic               done;
		mode_t              m_c;
		logic [DEPTH_W-1:0] d_c;
		logic [2:0]         lp_c;
		logic [2:0]         hx_c;
		logic [1:0]         lk_c;
		logic               t_c;
		logic               we_c;

		b    = doc.data_byte;
		ok   = 1'b1;
		sv   = 1'b0;
		av   = 1'b0;
		done = 1'b0;
		m_c  = mode_q;
		d_c  = depth_q;
		lp_c = lpos_q;
		hx_c = hex_q;
		lk_c = lkind_q;
		t_c  = top_q;
		we_c = 1'b0;

		mode_n  = mode_q;
		depth_n = depth_q;
		lpos_n  = lpos_q;
		hex_n   = hex_q;
		lkind_n = lkind_q;
		rej_n   = rej_q;
		top_n   = top_q;
		mem_we  = 1'b0;
		mem_wa  = depth_q[ADDR_W-1:0];
		mem_wd  = 1'b0;

		unique case (mode_q) inside
			M_VALUE: sv = 1'b1;
			M_ARR_FIRST: begin
				if (b == "]") begin
					d_c = depth_q - DEPTH_W'(1);
					t_c = below_q;
					m_c = M_AFTER;
				end else begin
					sv = 1'b1;
				end
			end
			M_OBJ_FIRST: begin
				if (b == "}") begin
					d_c = depth_q - DEPTH_W'(1);
					t_c = below_q;
					m_c = M_AFTER;
				end else if (b == "\"") begin
					m_c = M_KSTR;
				end else begin
					ok = is_ws(b);
				end
			end
			M_KEY: begin
				if (b == "\"") m_c = M_KSTR;
				else ok = is_ws(b);
			end
			M_COLON: begin
				if (b == ":") m_c = M_VALUE;
				else ok = is_ws(b);
			end
			M_AFTER: av = 1'b1;
			M_VSTR, M_KSTR: begin
				if (b == "\"") begin
					m_c = (mode_q == M_VSTR) ? M_AFTER : M_COLON;
				end else if (b < 8'h20) begin
					ok = 1'b0;
				end else if (b == "\\") begin
					m_c = (mode_q == M_VSTR) ? M_VESC : M_KESC;
				end
			end
			M_VESC, M_KESC: begin
				if (b == "u") begin
					hx_c = 3'd0;
					m_c  = (mode_q == M_VESC) ? M_VHEX : M_KHEX;
				end else if (b == "\"" || b == "\\" || b == "/" || b == "b" ||
					b == "f" || b == "n" || b == "r" || b == "t") begin
					m_c = (mode_q == M_VESC) ? M_VSTR : M_KSTR;
				end else begin
					ok = 1'b0;
				end
			end
			M_VHEX, M_KHEX: begin
				if (!is_hex(b)) begin
					ok = 1'b0;
				end else if (hex_q + 3'd1 >= 3'd4) begin
					hx_c = 3'd0;
					m_c  = (mode_q == M_VHEX) ? M_VSTR : M_KSTR;
				end else begin
					hx_c = hex_q + 3'd1;
				end
			end
			M_LIT: begin
				if (lkind_q > LIT_NULL || lpos_q >= lit_len(lkind_q) ||
					b != lit_char(lkind_q, lpos_q)) begin
					ok = 1'b0;
				end else if (lpos_q + 3'd1 == lit_len(lkind_q)) begin
					lp_c = 3'd0;
					m_c  = M_AFTER;
				end else begin
					lp_c = lpos_q + 3'd1;
				end
			end
			M_NMINUS: begin
				if (b == "0") m_c = M_NZERO;
				else if (is_digit(b)) m_c = M_NINT;
				else ok = 1'b0;
			end
			M_NZERO, M_NINT: begin
				if (mode_q == M_NINT && is_digit(b)) m_c = M_NINT;
				else if (b == ".") m_c = M_NDOT;
				else if (b == "e" || b == "E") m_c = M_NE;
				else av = 1'b1;
			end
			M_NDOT: begin
				if (is_digit(b)) m_c = M_NFRAC;
				else ok = 1'b0;
			end
			M_NFRAC: begin
				if (is_digit(b)) m_c = M_NFRAC;
				else if (b == "e" || b == "E") m_c = M_NE;
				else av = 1'b1;
			end
			M_NE: begin
				if (b == "+" || b == "-") m_c = M_NESIGN;
				else if (is_digit(b)) m_c = M_NEXP;
				else ok = 1'b0;
			end
			M_NESIGN: begin
				if (is_digit(b)) m_c = M_NEXP;
				else ok = 1'b0;
			end
			M_NEXP: begin
				if (is_digit(b)) m_c = M_NEXP;
				else av = 1'b1;
			end
			default: ok = 1'b0;
		endcase

		if (sv) begin
			if (is_ws(b)) begin
				m_c = mode_q;
			end else if (b == "\"") begin
				m_c = M_VSTR;
			end else if (b == "{" || b == "[") begin
				if (depth_q >= limit) begin
					ok = 1'b0;
				end else begin
					we_c = 1'b1;
					t_c  = (b == "{");
					d_c  = depth_q + DEPTH_W'(1);
					m_c  = (b == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
				end
			end else if (b == "t" || b == "f" || b == "n") begin
				lk_c = (b == "t") ? LIT_TRUE : ((b == "f") ? LIT_FALSE : LIT_NULL);
				lp_c = 3'd1;
				m_c  = M_LIT;
			end else if (b == "-") begin
				m_c = M_NMINUS;
			end else if (b == "0") begin
				m_c = M_NZERO;
			end else if (is_digit(b)) begin
				m_c = M_NINT;
			end else begin
				ok = 1'b0;
			end
		end

		if (av) begin
			m_c = M_AFTER;
			if (!is_ws(b)) begin
				if (depth_q == '0) begin
					ok = 1'b0;
				end else if (b == ",") begin
					m_c = top_q ? M_KEY : M_VALUE;
				end else if ((top_q && b == "}") || (!top_q && b == "]")) begin
					d_c = depth_q - DEPTH_W'(1);
					t_c = below_q;
				end else begin
					ok = 1'b0;
				end
			end
		end

		if (acc && !rej_q) begin
			if (ok) begin
				mode_n  = m_c;
				depth_n = d_c;
				lpos_n  = lp_c;
				hex_n   = hx_c;
				lkind_n = lk_c;
				top_n   = t_c;
				mem_we  = we_c;
				mem_wd  = t_c;
			end else begin
				rej_n = 1'b1;
			end
		end

		done = (depth_n == '0) && (mode_n == M_AFTER || mode_n == M_NZERO ||
			mode_n == M_NINT || mode_n == M_NFRAC || mode_n == M_NEXP);
		res.level = depth_n;
		if (rej_n) res.status = ST_REJECT;
		else if (doc.last_byte) res.status = done ? ST_ACCEPT : ST_REJECT;
		else res.status = ST_PENDING;

		// end of document: start over
		if (acc && doc.last_byte) begin
			mode_n  = M_VALUE;
			depth_n = '0;
			lpos_n  = 3'd0;
			hex_n   = 3'd0;
			lkind_n = LIT_TRUE;
			rej_n   = 1'b0;
		end

		// prefetch the entry under the next top
		mem_ra = ADDR_W'(depth_n - DEPTH_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_VALUE;
			depth_q <= '0;
			lpos_q  <= 3'd0;
			hex_q   <= 3'd0;
			lkind_q <= LIT_TRUE;
			rej_q   <= 1'b0;
			top_q   <= 1'b0;
		end else begin
			mode_q  <= mode_n;
			depth_q <= depth_n;
			lpos_q  <= lpos_n;
			hex_q   <= hex_n;
			lkind_q <= lkind_n;
			rej_q   <= rej_n;
			top_q   <= top_n;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		below_q <= stack_mem[mem_ra];
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(acc) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
			slot0_q <= res;
		end else if (pop && cnt_q == 2'd2) begin
			slot0_q <= slot1_q;
		end
		if (acc && cnt_q == 2'd1 && !pop) begin
			slot1_q <= res;
		end
	end

	assign verdict.valid         = (cnt_q != 2'd0);
	assign verdict.status        = slot0_q.status;
	assign verdict.nesting_level = slot0_q.level;

endmodule
